### rtl/core/skt_pkg.sv
// Shared constants, codes and types of the sorted key table.
`timescale 1ns / 1ps
package skt_pkg;

  localparam int CAPACITY_DEF      = 32;
  localparam int KEY_WIDTH_DEF     = 32;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  localparam int ACTION_W     = 3;
  localparam int KEY_IN_W     = 32;
  localparam int PAYLOAD_IN_W = 32;
  localparam int STATUS_W     = 2;
  localparam int COUNT_OUT_W  = 6;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_ERASE  = 3'd1,
    ACT_FIND   = 3'd2,
    ACT_LBOUND = 3'd3,
    ACT_LIST   = 3'd4,
    ACT_CLEAR  = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE = 2'd0,
    STS_MISS = 2'd1,
    STS_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_EVAL,
    S_SHUP,
    S_SHDN,
    S_WRITE,
    S_LRD,
    S_LOUT,
    S_RESP
  } state_t;

endpackage

### rtl/core/skt_if.sv
// Request and response channel interfaces of the sorted key table.
`timescale 1ns / 1ps
interface skt_req_if;
  import skt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ACTION_W-1:0]     action;
  logic [KEY_IN_W-1:0]     key;
  logic [PAYLOAD_IN_W-1:0] payload;

  modport source (output valid, action, key, payload, input ready);
  modport sink   (input valid, action, key, payload, output ready);
endinterface

interface skt_rsp_if;
  import skt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [KEY_IN_W-1:0]     result_key;
  logic [PAYLOAD_IN_W-1:0] result_payload;
  logic [COUNT_OUT_W-1:0]  entry_count;
  logic                    last;

  modport source (output valid, status, result_key, result_payload, entry_count, last,
                  input ready);
  modport sink   (input valid, status, result_key, result_payload, entry_count, last,
                  output ready);
endinterface

### rtl/core/sorted_key_table.sv
// Sorted key table: ordered set of key and payload entries held in one memory.
//
// Requests arrive on req (action, key, payload) and are taken when valid and
// ready are both high; ready is high only while the table is idle, so one
// request is worked on at a time. Results leave on rsp through an output
// register, one per request except for a list, which gives one result per
// entry in ascending key order with last set on the final one, or a single
// miss with last set when the table is empty.
// Steps: insert, erase, find and lower bound run a binary search over the
// entries, then probe the slot it settled on; insert or erase then moves
// the entries above that slot one at a time, insert writes the new entry,
// and the result is loaded. A list reads and then outputs each entry in
// turn; clear and unknown actions go straight to the result.
// The simple dual-port entry memory (one read, one write a cycle, registered
// read data) paces these steps: every compare and every move goes through it.
// Reset empties the table (count zero); entry contents are left as they are
// and never used before written. A stalled receiver holds the result in
// the output register and the sequencer waits; no result is dropped.
`timescale 1ns / 1ps
module sorted_key_table #(
  parameter int CAPACITY      = skt_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH     = skt_pkg::KEY_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = skt_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  skt_req_if.sink  req,
  skt_rsp_if.source rsp
);
  import skt_pkg::*;

  localparam int KW = KEY_WIDTH;
  localparam int PW = PAYLOAD_WIDTH;
  localparam int EW = KW + PW;
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // entry memory: key in the upper bits, payload below
  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] mem_rd;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [IW-1:0] mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rd <= mem[mem_raddr];
  end

  logic [KW-1:0] rd_key;
  logic [PW-1:0] rd_payload;
  assign rd_key     = mem_rd[EW-1 -: KW];
  assign rd_payload = mem_rd[PW-1:0];

  state_t state, state_next;

  logic [ACTION_W-1:0]    cur_action, cur_action_next;
  logic [KW-1:0]          cur_key, cur_key_next;
  logic [PW-1:0]          cur_payload, cur_payload_next;
  logic [CW-1:0]          count, count_next;
  logic [CW-1:0]          lo, lo_next;
  logic [CW-1:0]          hi, hi_next;
  logic [IW-1:0]          mid, mid_next;
  logic [IW-1:0]          rd_idx, rd_idx_next;
  status_t                resp_status, resp_status_next;
  logic [KW-1:0]          resp_key, resp_key_next;
  logic [PW-1:0]          resp_payload, resp_payload_next;

  logic                   out_valid, out_valid_next;
  logic [STATUS_W-1:0]    out_status, out_status_next;
  logic [KEY_IN_W-1:0]    out_key, out_key_next;
  logic [PAYLOAD_IN_W-1:0] out_payload, out_payload_next;
  logic [COUNT_OUT_W-1:0] out_count, out_count_next;
  logic                   out_last, out_last_next;

  logic [CW:0]   mid_sum;
  logic          out_free;
  logic          found;
  logic          in_range;
  logic [IW-1:0] top_idx;

  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign out_free = !out_valid || rsp.ready;
  assign in_range = lo < count;
  assign found    = in_range && (rd_key == cur_key);
  assign top_idx  = IW'(count - CW'(1));

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.result_key     = out_key;
  assign rsp.result_payload = out_payload;
  assign rsp.entry_count    = out_count;
  assign rsp.last           = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_action   <= cur_action_next;
    cur_key      <= cur_key_next;
    cur_payload  <= cur_payload_next;
    lo           <= lo_next;
    hi           <= hi_next;
    mid          <= mid_next;
    rd_idx       <= rd_idx_next;
    resp_status  <= resp_status_next;
    resp_key     <= resp_key_next;
    resp_payload <= resp_payload_next;
    out_status   <= out_status_next;
    out_key      <= out_key_next;
    out_payload  <= out_payload_next;
    out_count    <= out_count_next;
    out_last     <= out_last_next;
  end

  always_comb begin
    state_next        = state;
    cur_action_next   = cur_action;
    cur_key_next      = cur_key;
    cur_payload_next  = cur_payload;
    count_next        = count;
    lo_next           = lo;
    hi_next           = hi;
    mid_next          = mid;
    rd_idx_next       = rd_idx;
    resp_status_next  = resp_status;
    resp_key_next     = resp_key;
    resp_payload_next = resp_payload;
    out_valid_next    = out_valid && !rsp.ready;
    out_status_next   = out_status;
    out_key_next      = out_key;
    out_payload_next  = out_payload;
    out_count_next    = out_count;
    out_last_next     = out_last;
    mem_we            = 1'b0;
    mem_waddr         = rd_idx;
    mem_wdata         = mem_rd;
    mem_raddr         = rd_idx;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          cur_action_next   = req.action;
          cur_key_next      = KW'(req.key);
          cur_payload_next  = PW'(req.payload);
          resp_key_next     = '0;
          resp_payload_next = '0;
          lo_next           = '0;
          hi_next           = count;
          rd_idx_next       = '0;
          unique case (req.action) inside
            ACT_INSERT, ACT_ERASE, ACT_FIND, ACT_LBOUND: begin
              state_next = S_SRCH;
            end
            ACT_LIST: begin
              if (count == '0) begin
                resp_status_next = STS_MISS;
                state_next       = S_RESP;
              end else begin
                state_next = S_LRD;
              end
            end
            ACT_CLEAR: begin
              count_next       = '0;
              resp_status_next = STS_DONE;
              state_next       = S_RESP;
            end
            default: begin
              resp_status_next = STS_MISS;
              state_next       = S_RESP;
            end
          endcase
        end
      end

      S_SRCH: begin
        if (lo < hi) begin
          mid_next   = IW'(mid_sum[CW:1]);
          mem_raddr  = IW'(mid_sum[CW:1]);
          state_next = S_CMP;
        end else begin
          // probe the slot the search settled on
          mem_raddr  = IW'(lo);
          state_next = S_EVAL;
        end
      end

      S_CMP: begin
        if (rd_key < cur_key) begin
          lo_next = CW'(mid) + CW'(1);
        end else begin
          hi_next = CW'(mid);
        end
        state_next = S_SRCH;
      end

      S_EVAL: begin
        resp_key_next     = '0;
        resp_payload_next = '0;
        resp_status_next  = STS_MISS;
        state_next        = S_RESP;
        unique case (cur_action)
          ACT_INSERT: begin
            if (found) begin
              resp_status_next = STS_MISS;
            end else if (count >= CW'(CAPACITY)) begin
              resp_status_next = STS_FULL;
            end else if (in_range) begin
              // open a gap: move entries up, highest first
              mem_raddr   = top_idx;
              rd_idx_next = top_idx;
              state_next  = S_SHUP;
            end else begin
              state_next = S_WRITE;
            end
          end
          ACT_ERASE: begin
            if (!found) begin
              resp_status_next = STS_MISS;
            end else if (lo + CW'(1) < count) begin
              mem_raddr   = IW'(lo + CW'(1));
              rd_idx_next = IW'(lo + CW'(1));
              state_next  = S_SHDN;
            end else begin
              count_next       = count - CW'(1);
              resp_status_next = STS_DONE;
            end
          end
          ACT_FIND: begin
            if (found) begin
              resp_status_next  = STS_DONE;
              resp_key_next     = rd_key;
              resp_payload_next = rd_payload;
            end
          end
          ACT_LBOUND: begin
            if (in_range) begin
              resp_status_next  = STS_DONE;
              resp_key_next     = rd_key;
              resp_payload_next = rd_payload;
            end
          end
          default: begin
            resp_status_next = STS_MISS;
          end
        endcase
      end

      S_SHUP: begin
        mem_we    = 1'b1;
        mem_waddr = rd_idx + IW'(1);
        mem_wdata = mem_rd;
        if (rd_idx == IW'(lo)) begin
          state_next = S_WRITE;
        end else begin
          mem_raddr   = rd_idx - IW'(1);
          rd_idx_next = rd_idx - IW'(1);
        end
      end

      S_WRITE: begin
        mem_we           = 1'b1;
        mem_waddr        = IW'(lo);
        mem_wdata        = {cur_key, cur_payload};
        count_next       = count + CW'(1);
        resp_status_next = STS_DONE;
        state_next       = S_RESP;
      end

      S_SHDN: begin
        mem_we    = 1'b1;
        mem_waddr = rd_idx - IW'(1);
        mem_wdata = mem_rd;
        if (rd_idx == top_idx) begin
          count_next       = count - CW'(1);
          resp_status_next = STS_DONE;
          state_next       = S_RESP;
        end else begin
          mem_raddr   = rd_idx + IW'(1);
          rd_idx_next = rd_idx + IW'(1);
        end
      end

      S_LRD: begin
        mem_raddr  = rd_idx;
        state_next = S_LOUT;
      end

      S_LOUT: begin
        if (out_free) begin
          out_valid_next   = 1'b1;
          out_status_next  = STS_DONE;
          out_key_next     = KEY_IN_W'(rd_key);
          out_payload_next = PAYLOAD_IN_W'(rd_payload);
          out_count_next   = COUNT_OUT_W'(count);
          out_last_next    = (rd_idx == top_idx);
          if (rd_idx == top_idx) begin
            state_next = S_IDLE;
          end else begin
            rd_idx_next = rd_idx + IW'(1);
            state_next  = S_LRD;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_next   = 1'b1;
          out_status_next  = resp_status;
          out_key_next     = KEY_IN_W'(resp_key);
          out_payload_next = PAYLOAD_IN_W'(resp_payload);
          out_count_next   = COUNT_OUT_W'(count);
          out_last_next    = 1'b1;
          state_next       = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/skt_checker.sv
// Port-level assertions for the sorted key table, bound to its top level.
`timescale 1ns / 1ps
module skt_checker #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [skt_pkg::STATUS_W-1:0]    rsp_status,
  input logic [skt_pkg::KEY_IN_W-1:0]    rsp_result_key,
  input logic [skt_pkg::PAYLOAD_IN_W-1:0] rsp_result_payload,
  input logic [skt_pkg::COUNT_OUT_W-1:0] rsp_entry_count
);
  import skt_pkg::*;

  // one request at a time: the table is busy right after taking one
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one still in progress");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == STS_FULL) |-> rsp_entry_count == COUNT_OUT_W'(CAPACITY))
    else $error("full status with table not full");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != STS_DONE) |->
      (rsp_result_key == '0) && (rsp_result_payload == '0))
    else $error("failed response carries entry data");

endmodule

bind sorted_key_table skt_checker #(.CAPACITY(CAPACITY)) u_skt_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_result_key     (rsp.result_key),
  .rsp_result_payload (rsp.result_payload),
  .rsp_entry_count    (rsp.entry_count)
);
